// ===== hw/rtl/dda_pkg.sv =====
// Package for the DDA line rasterizer: widths, register indexes, FSM states,
// payload structs and controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package dda_pkg;

	localparam int INC_FRAC_BITS = 16;
	localparam int COORD_W       = 24;
	localparam int COORD_FRAC    = 8;
	localparam int POS_SHIFT     = INC_FRAC_BITS - COORD_FRAC;
	localparam int POS_W         = 40;
	localparam int INT_W         = POS_W - INC_FRAC_BITS;
	localparam int DELTA_W       = COORD_W + 1;
	localparam int STEP_W        = 16;
	localparam int DIV_BITS      = DELTA_W + POS_SHIFT;
	localparam int DIV_CNT_W     = $clog2(DIV_BITS);
	localparam int COLOR_W       = 32;
	localparam int PIX_W         = 12;
	localparam int SCREEN_W      = 13;
	localparam int SCREEN_MAX    = 4096;
	localparam int CFG_IDX_W     = 1;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                      kind;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic [COLOR_W-1:0]        line_color;
	} seg_in_t;

	typedef struct packed {
		logic               pixel_valid;
		logic [PIX_W-1:0]   pixel_x;
		logic [PIX_W-1:0]   pixel_y;
		logic [COLOR_W-1:0] pixel_color;
		logic               last_step;
		logic               idle;
	} pix_out_t;

	typedef struct packed {
		logic load_seg;
		logic div_step;
		logic push_load;
		logic push_step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

// ===== hw/rtl/dda_ifs.sv =====
// Valid/ready channel interfaces: segment requests in, pixel results out.
// Depends on dda_pkg.
`timescale 1ns / 1ps

interface dda_cmd_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic signed [dda_pkg::COORD_W-1:0]  start_x;
	logic signed [dda_pkg::COORD_W-1:0]  start_y;
	logic signed [dda_pkg::COORD_W-1:0]  end_x;
	logic signed [dda_pkg::COORD_W-1:0]  end_y;
	logic [dda_pkg::COLOR_W-1:0]         line_color;

	modport source (output valid, kind, start_x, start_y, end_x, end_y, line_color,
		input ready);
	modport sink (input valid, kind, start_x, start_y, end_x, end_y, line_color,
		output ready);
endinterface

interface dda_pix_if;
	logic                        valid;
	logic                        ready;
	logic                        pixel_valid;
	logic [dda_pkg::PIX_W-1:0]   pixel_x;
	logic [dda_pkg::PIX_W-1:0]   pixel_y;
	logic [dda_pkg::COLOR_W-1:0] pixel_color;
	logic                        last_step;
	logic                        idle;

	modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_step,
		idle, input ready);
	modport sink (input valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_step,
		idle, output ready);
endinterface

// ===== hw/rtl/dda_ctrl.sv =====
// Controller FSM: accepts requests, sequences the serial divider on a segment
// load and issues commands to the datapath. Depends on dda_pkg.
`timescale 1ns / 1ps

module dda_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_kind,
	input  dda_pkg::dp_status_t status,
	output logic                in_ready,
	output dda_pkg::ctrl_cmd_t  cmd
);

	dda_pkg::state_t                  state_q;
	dda_pkg::state_t                  state_nxt;
	logic [dda_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic                             div_last;
	logic                             accept;
	logic                             take;

	assign div_last = (cnt_q == dda_pkg::DIV_CNT_W'(dda_pkg::DIV_BITS - 1));
	assign accept   = in_valid && in_ready;
	assign take     = in_valid && status.out_free;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dda_pkg::ST_IDLE: begin
				if (accept && in_kind == dda_pkg::KIND_LOAD)
					state_nxt = dda_pkg::ST_DIV;
			end
			dda_pkg::ST_DIV: begin
				if (div_last)
					state_nxt = dda_pkg::ST_DONE;
			end
			dda_pkg::ST_DONE: begin
				if (status.out_free)
					state_nxt = dda_pkg::ST_IDLE;
			end
			default: state_nxt = dda_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			dda_pkg::ST_IDLE: begin
				in_ready      = status.out_free;
				cmd.load_seg  = take && in_kind == dda_pkg::KIND_LOAD;
				cmd.push_step = take && in_kind == dda_pkg::KIND_STEP;
			end
			dda_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			dda_pkg::ST_DONE: begin
				cmd.push_load = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dda_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_seg)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

// ===== hw/rtl/dda_dp.sv =====
// Datapath: segment state, screen registers, two restoring dividers sharing one
// sequence, the step/advance logic and the output register. Depends on dda_pkg.
`timescale 1ns / 1ps

module dda_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dda_pkg::ctrl_cmd_t                   cmd,
	output dda_pkg::dp_status_t                  status,
	input  dda_pkg::seg_in_t                     seg,
	input  logic                                 cfg_wen,
	input  logic [dda_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dda_pkg::SCREEN_W-1:0]         cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output dda_pkg::pix_out_t                    out_item
);

	localparam int PW = dda_pkg::POS_W;
	localparam int DW = dda_pkg::DELTA_W;
	localparam int QW = dda_pkg::DIV_BITS;
	localparam int SW = dda_pkg::STEP_W;
	localparam int IW = dda_pkg::INT_W;
	localparam int CW = dda_pkg::COORD_W;

	logic signed [PW-1:0]          pos_x_q, pos_y_q, inc_x_q, inc_y_q;
	logic [SW-1:0]                 steps_q;
	logic [dda_pkg::COLOR_W-1:0]   color_q;
	logic [dda_pkg::SCREEN_W-1:0]  width_q, height_q;
	logic [QW-1:0]                 quo_x_q, quo_y_q;
	logic [SW-1:0]                 rem_x_q, rem_y_q;
	logic                          neg_x_q, neg_y_q;
	logic                          out_valid_q;
	dda_pkg::pix_out_t             out_q;

	logic signed [DW-1:0]          dx, dy;
	logic [DW-1:0]                 ax, ay, big;
	logic [SW:0]                   trial_x, trial_y, diff_x, diff_y;
	logic signed [PW-1:0]          qx_ext, qy_ext, inc_x_new, inc_y_new;
	logic [dda_pkg::SCREEN_W-1:0]  w_eff, h_eff;
	logic [IW-1:0]                 xi, yi;
	logic                          on_x, on_y, has_steps;
	dda_pkg::pix_out_t             step_res, load_res;

	assign dx  = {seg.end_x[CW-1], seg.end_x} - {seg.start_x[CW-1], seg.start_x};
	assign dy  = {seg.end_y[CW-1], seg.end_y} - {seg.start_y[CW-1], seg.start_y};
	assign ax  = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign ay  = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign big = (ax > ay) ? ax : ay;

	assign trial_x = {rem_x_q, quo_x_q[QW-1]};
	assign trial_y = {rem_y_q, quo_y_q[QW-1]};
	assign diff_x  = trial_x - {1'b0, steps_q};
	assign diff_y  = trial_y - {1'b0, steps_q};

	assign qx_ext    = PW'(quo_x_q);
	assign qy_ext    = PW'(quo_y_q);
	assign inc_x_new = neg_x_q ? -qx_ext : qx_ext;
	assign inc_y_new = neg_y_q ? -qy_ext : qy_ext;

	assign w_eff = (width_q > dda_pkg::SCREEN_W'(dda_pkg::SCREEN_MAX))
		? dda_pkg::SCREEN_W'(dda_pkg::SCREEN_MAX) : width_q;
	assign h_eff = (height_q > dda_pkg::SCREEN_W'(dda_pkg::SCREEN_MAX))
		? dda_pkg::SCREEN_W'(dda_pkg::SCREEN_MAX) : height_q;

	assign xi   = pos_x_q[PW-1:dda_pkg::INC_FRAC_BITS];
	assign yi   = pos_y_q[PW-1:dda_pkg::INC_FRAC_BITS];
	assign on_x = !pos_x_q[PW-1] && (xi != '0) && (xi < IW'(w_eff));
	assign on_y = !pos_y_q[PW-1] && (yi != '0) && (yi < IW'(h_eff));
	assign has_steps = (steps_q != '0);

	always_comb begin
		step_res = '0;
		if (has_steps) begin
			if (on_x && on_y) begin
				step_res.pixel_valid = 1'b1;
				step_res.pixel_x     = xi[dda_pkg::PIX_W-1:0];
				step_res.pixel_y     = yi[dda_pkg::PIX_W-1:0];
				step_res.pixel_color = color_q;
			end
			step_res.last_step = (steps_q == SW'(1));
			step_res.idle      = (steps_q == SW'(1));
		end else begin
			step_res.idle = 1'b1;
		end
	end

	always_comb begin
		load_res      = '0;
		load_res.idle = !has_steps;
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_item        = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q     <= '0;
			width_q     <= dda_pkg::SCREEN_W'(1920);
			height_q    <= dda_pkg::SCREEN_W'(1080);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen && cfg_index == dda_pkg::REG_SCREEN_WIDTH)
				width_q <= cfg_data;
			if (cfg_wen && cfg_index == dda_pkg::REG_SCREEN_HEIGHT)
				height_q <= cfg_data;
			if (cmd.load_seg)
				steps_q <= big[dda_pkg::COORD_FRAC +: SW];
			else if (cmd.push_step && has_steps)
				steps_q <= steps_q - 1'b1;
			if (cmd.push_load || cmd.push_step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_seg) begin
			pos_x_q <= PW'(seg.start_x) <<< dda_pkg::POS_SHIFT;
			pos_y_q <= PW'(seg.start_y) <<< dda_pkg::POS_SHIFT;
			color_q <= seg.line_color;
			quo_x_q <= {ax, {dda_pkg::POS_SHIFT{1'b0}}};
			quo_y_q <= {ay, {dda_pkg::POS_SHIFT{1'b0}}};
			rem_x_q <= '0;
			rem_y_q <= '0;
			neg_x_q <= dx[DW-1];
			neg_y_q <= dy[DW-1];
		end else if (cmd.div_step) begin
			rem_x_q <= diff_x[SW] ? trial_x[SW-1:0] : diff_x[SW-1:0];
			rem_y_q <= diff_y[SW] ? trial_y[SW-1:0] : diff_y[SW-1:0];
			quo_x_q <= {quo_x_q[QW-2:0], !diff_x[SW]};
			quo_y_q <= {quo_y_q[QW-2:0], !diff_y[SW]};
		end else if (cmd.push_step && has_steps) begin
			pos_x_q <= pos_x_q + inc_x_q;
			pos_y_q <= pos_y_q + inc_y_q;
		end
		if (cmd.push_load) begin
			inc_x_q <= has_steps ? inc_x_new : '0;
			inc_y_q <= has_steps ? inc_y_new : '0;
			out_q   <= load_res;
		end else if (cmd.push_step) begin
			out_q <= step_res;
		end
	end

endmodule

// ===== hw/rtl/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer: joins controller and datapath to the
// request/pixel channels and the config port. Depends on dda_pkg, dda_ifs,
// dda_ctrl and dda_dp.
//
//   port      | dir | handshake     | carries
//   cmd       | in  | valid/ready   | kind, start/end points, line color
//   pixel     | out | valid/ready   | pixel flag, x, y, color, last, idle
//   cfg_*     | in  | write enable  | screen width / height
//
// Step requests give one pixel per cycle while the sink keeps up.
// A load request is accepted in ST_IDLE, runs the bit-serial restoring divider
// in ST_DIV and commits increments in ST_DONE once the output register frees.
// Reset clears the FSM, step count and output valid; screen is 1920 x 1080.
// A stalled pixel output holds the request side until the register frees.
`timescale 1ns / 1ps

module dda_line_rasterizer (
	input  logic                            clk,
	input  logic                            arst_n,
	dda_cmd_if.sink                         cmd,
	dda_pix_if.source                       pixel,
	input  logic                            cfg_wen,
	input  logic [dda_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dda_pkg::SCREEN_W-1:0]    cfg_data
);

	dda_pkg::ctrl_cmd_t   ctrl_cmd;
	dda_pkg::dp_status_t  dp_status;
	dda_pkg::seg_in_t     seg;
	dda_pkg::pix_out_t    out_item;

	assign seg.kind       = cmd.kind;
	assign seg.start_x    = cmd.start_x;
	assign seg.start_y    = cmd.start_y;
	assign seg.end_x      = cmd.end_x;
	assign seg.end_y      = cmd.end_y;
	assign seg.line_color = cmd.line_color;

	dda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_kind  (cmd.kind),
		.status   (dp_status),
		.in_ready (cmd.ready),
		.cmd      (ctrl_cmd)
	);

	dda_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctrl_cmd),
		.status    (dp_status),
		.seg       (seg),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (pixel.valid),
		.out_ready (pixel.ready),
		.out_item  (out_item)
	);

	assign pixel.pixel_valid = out_item.pixel_valid;
	assign pixel.pixel_x     = out_item.pixel_x;
	assign pixel.pixel_y     = out_item.pixel_y;
	assign pixel.pixel_color = out_item.pixel_color;
	assign pixel.last_step   = out_item.last_step;
	assign pixel.idle        = out_item.idle;

endmodule

// ===== hw/rtl/dda_chk.sv =====
// Port-level checker for the DDA line rasterizer, bound to the top level.
// Depends on dda_pkg and dda_line_rasterizer.
`timescale 1ns / 1ps

module dda_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          in_kind,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          pixel_valid,
	input logic [dda_pkg::PIX_W-1:0]     pixel_x,
	input logic [dda_pkg::PIX_W-1:0]     pixel_y,
	input logic [dda_pkg::COLOR_W-1:0]   pixel_color,
	input logic                          last_step,
	input logic                          idle
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pixel request dropped while stalled");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_step |-> idle)
		else $error("last step without idle");

	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0 && pixel_color == '0)
		else $error("invalid pixel carries data");

	a_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_valid |-> pixel_x != '0 && pixel_y != '0)
		else $error("valid pixel on screen edge");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_kind == dda_pkg::KIND_LOAD |=> !in_ready)
		else $error("request taken during divide");

endmodule

bind dda_line_rasterizer dda_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (cmd.valid),
	.in_ready    (cmd.ready),
	.in_kind     (cmd.kind),
	.out_valid   (pixel.valid),
	.out_ready   (pixel.ready),
	.pixel_valid (pixel.pixel_valid),
	.pixel_x     (pixel.pixel_x),
	.pixel_y     (pixel.pixel_y),
	.pixel_color (pixel.pixel_color),
	.last_step   (pixel.last_step),
	.idle        (pixel.idle)
);
